// File: rtl/core/lrv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrv_pkg
// Types and fixed-point constants shared by the radial vignette pipeline.
// ----------------------------------------------------------------------------
package lrv_pkg;

  // configuration
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int SIDE_W     = 13;
  localparam int STR_W      = 17;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH     = 2'd2;

  localparam logic [SIDE_W-1:0] WIDTH_RESET    = 13'd640;
  localparam logic [SIDE_W-1:0] HEIGHT_RESET   = 13'd480;
  localparam logic [STR_W-1:0]  STRENGTH_RESET = 17'd45875;

  // datapath widths
  localparam int COORD_W = 12;
  localparam int DX_W    = 14;
  localparam int SQ_W    = 26;
  localparam int NUM_W   = 27;
  localparam int FRAC_W  = 32;
  localparam int QUOT_W  = 58;
  localparam int ROOT_W  = 29;
  localparam int PROD_W  = STR_W + ROOT_W;
  localparam int SUB_W   = PROD_W - 16;
  localparam int FACT_W  = 17;

  localparam logic [FACT_W-1:0] FACTOR_ONE   = 17'd65536;
  localparam logic [FACT_W-1:0] FACTOR_FLOOR = 17'd6554;
  localparam logic [SUB_W-1:0]  SUB_LIMIT    = SUB_W'(58982);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [7:0]         blue_in;
    logic [7:0]         green_in;
    logic [7:0]         red_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } pix_out_t;

  // scale one sample by a Q1.16 factor, round to nearest, saturate
  function automatic logic [7:0] scale_channel(input logic [7:0] v,
                                               input logic [FACT_W-1:0] f);
    logic [24:0] p;
    logic [24:0] s;
    logic [8:0]  r;
    p = 25'(v) * 25'(f);
    s = p + 25'd32768;
    r = s[24:16];
    scale_channel = (r > 9'd255) ? 8'd255 : r[7:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/lrv_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrv_div_pipe
// Pipelined restoring divider: (num << 32) / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lrv_div_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [lrv_pkg::NUM_W-1:0]  num,
  input  logic [lrv_pkg::NUM_W-1:0]  den,
  input  lrv_pkg::color_t            color_in,
  output logic                       out_valid,
  output logic [lrv_pkg::QUOT_W-1:0] quot,
  output lrv_pkg::color_t            color_out
);
  import lrv_pkg::*;

  logic              vld [1:QUOT_W];
  logic [NUM_W-1:0]  rem [1:QUOT_W];
  logic [NUM_W-1:0]  dvd [1:QUOT_W];
  logic [QUOT_W-1:0] quo [1:QUOT_W];
  color_t            col [1:QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    localparam int BIT = QUOT_W - 1 - k;
    logic              sv;
    logic [NUM_W-1:0]  sr;
    logic [NUM_W-1:0]  sn;
    logic [QUOT_W-1:0] sq;
    color_t            sc;
    logic              dbit;
    logic [NUM_W:0]    shifted;
    logic [NUM_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign sv = in_valid;
      assign sr = {(NUM_W-1)'(0), num[NUM_W-1]};
      assign sn = num;
      assign sq = '0;
      assign sc = color_in;
    end else begin : g_next
      assign sv = vld[k];
      assign sr = rem[k];
      assign sn = dvd[k];
      assign sq = quo[k];
      assign sc = col[k];
    end

    if (BIT >= FRAC_W) begin : g_num_bit
      assign dbit = sn[BIT-FRAC_W];
    end else begin : g_zero_bit
      assign dbit = 1'b0;
    end

    assign shifted = {sr, dbit};
    assign ge      = shifted >= {1'b0, den};
    assign diff    = shifted - {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
        dvd[k+1] <= sn;
        quo[k+1] <= {sq[QUOT_W-2:0], ge};
        col[k+1] <= sc;
      end
    end
  end

  assign out_valid = vld[QUOT_W];
  assign quot      = quo[QUOT_W];
  assign color_out = col[QUOT_W];

endmodule
`default_nettype wire

// File: rtl/core/lrv_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrv_sqrt_pipe
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lrv_sqrt_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [lrv_pkg::QUOT_W-1:0] rad,
  input  lrv_pkg::color_t            color_in,
  output logic                       out_valid,
  output logic [lrv_pkg::ROOT_W-1:0] root,
  output lrv_pkg::color_t            color_out
);
  import lrv_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic              vld [1:ROOT_W];
  logic [REM_W-1:0]  rem [1:ROOT_W];
  logic [ROOT_W-1:0] rt  [1:ROOT_W];
  logic [QUOT_W-1:0] rd  [1:ROOT_W];
  color_t            col [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int PAIR = ROOT_W - 1 - k;
    logic              sv;
    logic [REM_W-1:0]  sr;
    logic [ROOT_W-1:0] st;
    logic [QUOT_W-1:0] sd;
    color_t            sc;
    logic [REM_W+1:0]  shifted;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign sv = in_valid;
      assign sr = '0;
      assign st = '0;
      assign sd = rad;
      assign sc = color_in;
    end else begin : g_next
      assign sv = vld[k];
      assign sr = rem[k];
      assign st = rt[k];
      assign sd = rd[k];
      assign sc = col[k];
    end

    assign shifted = {sr, sd[2*PAIR+1:2*PAIR]};
    assign trial   = {2'b00, st, 2'b01};
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        rt[k+1]  <= {st[ROOT_W-2:0], ge};
        rd[k+1]  <= sd;
        col[k+1] <= sc;
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign color_out = col[ROOT_W];

endmodule
`default_nettype wire

// File: rtl/core/linear_radial_vignette_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_radial_vignette_unit
// Radial vignette: darkens each BGR pixel by a factor that falls linearly
// with distance from the image centre, floored at 0.1.
//
// Pixel requests arrive on pixel/pixel_valid/pixel_stall, results leave on
// result/result_valid/result_stall; a request moves when valid is high and
// stall is low. One result per pixel, in order.
// Between the input and result_valid lie 3 setup stages, 58 divider
// stages at one quotient bit each, 29 square-root stages at one root bit each
// and 3 scaling stages. Throughput: one pixel per cycle while not stalled.
// When result_stall holds a waiting result, the whole pipeline holds; one
// more pixel is taken into an input skid register, then pixel_stall rises.
// Reset clears all valid bits and loads the register defaults
// (640 x 480, strength 0.7). Write cfg_* only while the pipeline is empty.
// ----------------------------------------------------------------------------
module linear_radial_vignette_unit #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  lrv_pkg::pix_in_t               pixel,
  output logic                           result_valid,
  input  logic                           result_stall,
  output lrv_pkg::pix_out_t              result,
  input  logic                           cfg_we,
  input  logic [lrv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lrv_pkg::*;

  localparam logic [SIDE_W+1:0] SIDE_MAX   = (SIDE_W+2)'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_CLAMP =
    (MAX_SIDE > (2**SIDE_W - 1)) ? {SIDE_W{1'b1}} : SIDE_W'(MAX_SIDE);

  logic [SIDE_W-1:0] image_width;
  logic [SIDE_W-1:0] image_height;
  logic [STR_W-1:0]  vignette_strength;

  logic [SIDE_W-1:0]   wc;
  logic [SIDE_W-1:0]   hc;
  logic [2*SIDE_W-1:0] wsq;
  logic [2*SIDE_W-1:0] hsq;
  logic [NUM_W-1:0]    den;

  logic    en;
  logic    skid_v;
  pix_in_t skid;
  logic    src_v;
  pix_in_t src;
  color_t  src_col;

  logic                   a_v;
  logic signed [DX_W-1:0] a_dx;
  logic signed [DX_W-1:0] a_dy;
  color_t                 a_col;

  logic signed [2*DX_W-1:0] sqx_full;
  logic signed [2*DX_W-1:0] sqy_full;
  logic                     b_v;
  logic [SQ_W-1:0]          b_sqx;
  logic [SQ_W-1:0]          b_sqy;
  color_t                   b_col;

  logic             c_v;
  logic [NUM_W-1:0] c_num;
  color_t           c_col;

  logic              d_v;
  logic [QUOT_W-1:0] d_quot;
  color_t            d_col;

  logic              s_v;
  logic [ROOT_W-1:0] s_root;
  color_t            s_col;

  logic              p_v;
  logic [PROD_W-1:0] p_prod;
  color_t            p_col;

  logic [PROD_W-1:0] rnd;
  logic [SUB_W-1:0]  sub;
  logic [FACT_W-1:0] factor_next;
  logic              f_v;
  logic [FACT_W-1:0] f_factor;
  color_t            f_col;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= WIDTH_RESET;
      image_height      <= HEIGHT_RESET;
      vignette_strength <= STRENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width       <= cfg_data[SIDE_W-1:0];
        REG_IMAGE_HEIGHT: image_height      <= cfg_data[SIDE_W-1:0];
        REG_STRENGTH:     vignette_strength <= cfg_data[STR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wc = image_width;
    if (image_width == '0) begin
      wc = SIDE_W'(1);
    end else if ({2'b00, image_width} > SIDE_MAX) begin
      wc = SIDE_CLAMP;
    end
    hc = image_height;
    if (image_height == '0) begin
      hc = SIDE_W'(1);
    end else if ({2'b00, image_height} > SIDE_MAX) begin
      hc = SIDE_CLAMP;
    end
  end

  // centre-to-corner distance squared, doubled units
  always_ff @(posedge clk) begin
    wsq <= wc * wc;
    hsq <= hc * hc;
    den <= NUM_W'(wsq) + NUM_W'(hsq);
  end

  // input skid and global advance
  assign en          = !result_valid || !result_stall;
  assign pixel_stall = skid_v;
  assign src_v       = skid_v || pixel_valid;
  assign src         = skid_v ? skid : pixel;
  assign src_col     = '{blue: src.blue_in, green: src.green_in, red: src.red_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (en) begin
      skid_v <= 1'b0;
    end else if (pixel_valid && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && pixel_valid && !skid_v) begin
      skid <= pixel;
    end
  end

  // stage A: offsets from centre
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx  <= {1'b0, src.column, 1'b0} - {1'b0, wc};
      a_dy  <= {1'b0, src.row, 1'b0} - {1'b0, hc};
      a_col <= src_col;
    end
  end

  // stage B: squares
  assign sqx_full = a_dx * a_dx;
  assign sqy_full = a_dy * a_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sqx <= sqx_full[SQ_W-1:0];
      b_sqy <= sqy_full[SQ_W-1:0];
      b_col <= a_col;
    end
  end

  // stage C: squared distance
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_num <= NUM_W'(b_sqx) + NUM_W'(b_sqy);
      c_col <= b_col;
    end
  end

  lrv_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_v),
    .num       (c_num),
    .den       (den),
    .color_in  (c_col),
    .out_valid (d_v),
    .quot      (d_quot),
    .color_out (d_col)
  );

  lrv_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_v),
    .rad       (d_quot),
    .color_in  (d_col),
    .out_valid (s_v),
    .root      (s_root),
    .color_out (s_col)
  );

  // stage D: strength times ratio
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod <= PROD_W'(vignette_strength) * PROD_W'(s_root);
      p_col  <= s_col;
    end
  end

  // stage E: factor with floor
  assign rnd = p_prod + PROD_W'(32768);
  assign sub = rnd[PROD_W-1:16];

  always_comb begin
    if (sub >= SUB_LIMIT) begin
      factor_next = FACTOR_FLOOR;
    end else begin
      factor_next = FACTOR_ONE - sub[FACT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_factor <= factor_next;
      f_col    <= p_col;
    end
  end

  // output register: scale channels
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.blue_out  <= scale_channel(f_col.blue, f_factor);
      result.green_out <= scale_channel(f_col.green, f_factor);
      result.red_out   <= scale_channel(f_col.red, f_factor);
    end
  end

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (!en && pixel_valid && !pixel_stall) |=> pixel_stall)
    else $error("skid did not capture request during hold");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (pixel_stall && en) |=> (a_v && !pixel_stall))
    else $error("skid request not advanced into pipeline");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid)
    else $error("input stalled with no result waiting");

  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    f_v |-> (f_factor >= FACTOR_FLOOR && f_factor <= FACTOR_ONE))
    else $error("vignette factor out of range");

endmodule
`default_nettype wire
